// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst is high.
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while rst is high.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Types and constants shared by the LSB payload extractor and its checker.
// ----------------------------------------------------------------------------
package lpe_pkg;

  // Channels per pixel; the last channel of each pixel (alpha) is skipped.
  localparam int CHANNELS_PER_PIXEL = 4;
  localparam int PHASE_W = (CHANNELS_PER_PIXEL > 1) ? $clog2(CHANNELS_PER_PIXEL) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(CHANNELS_PER_PIXEL - 1);

  // Bits per payload byte and header bytes in the length field.
  localparam int BIT_CNT_W = 3;
  localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = 3'd7;
  localparam int HDR_CNT_W = 2;
  localparam logic [HDR_CNT_W-1:0] HDR_CNT_LAST = 2'd3;
  localparam int LEN_W = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MID_BYTE = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

endpackage

// ===== src/lsb_payload_extract.sv =====
// ----------------------------------------------------------------------------
// lsb_payload_extract
// Gathers the LSBs of the color channels of an RGBA byte stream into payload
// bytes behind a 32-bit big-endian length header.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid / in_ready   channel_byte, image_end
//  output   out_valid / out_ready data_byte, has_data, last_of_run, status
//
//  One channel word is accepted per cycle while the output is not stalled. A
//  word is held in the input register, and its result is then registered in
//  the result register, from which it is offered on the output.
//  The extraction state is updated once for each consumed word.
//  A stall on the output holds the result register and the input register;
//  in_ready drops only when both are full and the output is stalled.
//  rst is synchronous and returns the block to its idle, empty-header state.
// ----------------------------------------------------------------------------
module lsb_payload_extract (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] channel_byte,
  input  logic       image_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       has_data,
  output logic       last_of_run,
  output logic [1:0] status
);
  import lpe_pkg::*;

  // Input register.
  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_end;
  logic       stg_fire;

  // Extraction state.
  logic [PHASE_W-1:0]   channel_phase, channel_phase_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [LEN_W-1:0]     declared_length, declared_length_next;
  logic [LEN_W-1:0]     bytes_emitted, bytes_emitted_next;
  logic                 have_length, have_length_next;
  logic                 finished, finished_next;

  // Result of the current word.
  logic       produced;
  logic [7:0] res_data;
  logic       res_has;
  logic       res_last;
  status_t    res_status;

  // Working values.
  logic       skip;
  logic       byte_done;
  logic [7:0] shifted;

  assign stg_fire = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || stg_fire;

  // Input register: load on accept, empty when the word is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid <= 1'b1;
    end else if (stg_fire) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte <= channel_byte;
      stg_end  <= image_end;
    end
  end

  // Next state and result for the word in the input register.
  always_comb begin
    channel_phase_next   = channel_phase;
    bit_count_next       = bit_count;
    shift_byte_next      = shift_byte;
    header_count_next    = header_count;
    declared_length_next = declared_length;
    bytes_emitted_next   = bytes_emitted;
    have_length_next     = have_length;
    finished_next        = finished;
    produced             = 1'b0;
    res_data             = 8'd0;
    res_has              = 1'b0;
    res_last             = 1'b0;
    res_status           = ST_OK;

    skip      = (channel_phase == PHASE_LAST);
    byte_done = !skip && (bit_count == BIT_CNT_LAST);
    shifted   = {shift_byte[6:0], stg_byte[0]};

    if (!finished) begin
      channel_phase_next = skip ? '0 : channel_phase + 1'b1;

      // Shift in one LSB per color channel.
      if (!skip) begin
        bit_count_next  = bit_count + 1'b1;
        shift_byte_next = byte_done ? 8'd0 : shifted;
      end

      // A completed byte goes into the length header or out as data.
      if (byte_done) begin
        if (!have_length) begin
          declared_length_next = {declared_length[LEN_W-9:0], shifted};
          header_count_next    = header_count + 1'b1;
          if (header_count == HDR_CNT_LAST) begin
            have_length_next = 1'b1;
            if (declared_length_next == '0) begin
              produced      = 1'b1;
              res_last      = 1'b1;
              finished_next = 1'b1;
            end
          end
        end else begin
          produced           = 1'b1;
          res_has            = 1'b1;
          res_data           = shifted;
          bytes_emitted_next = bytes_emitted + 1'b1;
          if (bytes_emitted_next == declared_length) begin
            res_last      = 1'b1;
            finished_next = 1'b1;
          end
        end
      end

      // The image ended with the run still open: close it with an error.
      if (stg_end && !finished_next) begin
        res_last = 1'b1;
        if (produced) begin
          res_status = ST_SHORT;
        end else begin
          produced   = 1'b1;
          res_status = (bit_count_next != '0) ? ST_MID_BYTE : ST_SHORT;
        end
      end
    end

    // The last channel of the image always restarts the block.
    if (stg_end) begin
      channel_phase_next   = '0;
      bit_count_next       = '0;
      shift_byte_next      = 8'd0;
      header_count_next    = '0;
      declared_length_next = '0;
      bytes_emitted_next   = '0;
      have_length_next     = 1'b0;
      finished_next        = 1'b0;
    end
  end

  // State registers advance once per consumed word.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_phase   <= '0;
      bit_count       <= '0;
      shift_byte      <= 8'd0;
      header_count    <= '0;
      declared_length <= '0;
      bytes_emitted   <= '0;
      have_length     <= 1'b0;
      finished        <= 1'b0;
    end else if (stg_fire) begin
      channel_phase   <= channel_phase_next;
      bit_count       <= bit_count_next;
      shift_byte      <= shift_byte_next;
      header_count    <= header_count_next;
      declared_length <= declared_length_next;
      bytes_emitted   <= bytes_emitted_next;
      have_length     <= have_length_next;
      finished        <= finished_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_fire) begin
      out_valid <= produced;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire && produced) begin
      data_byte   <= res_data;
      has_data    <= res_has;
      last_of_run <= res_last;
      status      <= res_status;
    end
  end

endmodule

// ===== src/lpe_checker.sv =====
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks on the LSB payload extractor, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] channel_byte,
  input logic       image_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       has_data,
  input logic       last_of_run,
  input logic [1:0] status
);
  import lpe_pkg::*;

  // A waiting channel word stays offered and unchanged until it is taken.
  `CHK_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable({channel_byte, image_end}))

  // A stalled result stays offered with its word unchanged.
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(status))

  // Every error result closes the run.
  `CHK_IMPLY(a_err_last, out_valid && (status == ST_MID_BYTE || status == ST_SHORT), last_of_run)

  // A mid-byte error never carries a payload byte.
  `CHK_IMPLY(a_mid_empty, out_valid && status == ST_MID_BYTE, !has_data)

  // A result without payload shows a zero data byte.
  `CHK_IMPLY(a_empty_zero, out_valid && !has_data, data_byte == 8'd0)

endmodule

bind lsb_payload_extract lpe_checker u_lpe_checker (.*);
